### rtl/core/imc_pkg.sv
// ----------------------------------------------------------------------------
// IBAN mod-97 checker package
// Shared types, constants and mod-97 arithmetic for the checker blocks.
// ----------------------------------------------------------------------------
package imc_pkg;

    localparam int unsigned ROTATE_COUNT = 4;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [6:0]  MODULUS      = 7'd97;
    localparam logic [7:0]  LETTER_BIAS  = 8'd55;
    localparam logic [5:0]  SKIP_CODE    = 6'd63;
    localparam logic [5:0]  LAST_DIGIT   = 6'd9;
    localparam logic [5:0]  LAST_LETTER  = 6'd35;
    localparam logic [7:0]  MAX_COUNT    = 8'd255;
    // floor(2^20 / 97); the quotient estimate is at most one too small.
    localparam logic [13:0] MOD_RECIP    = 14'd10810;
    localparam int unsigned RECIP_SHIFT  = 20;

    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CHAR_NINE    = 8'h39;
    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
    localparam logic [7:0]  CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0]  CASE_OFFSET  = 8'd32;

    // One classified character on its way from the front to the back end.
    // The tail fields are meaningful on the last character only.
    typedef struct packed {
        logic [5:0] value;
        logic       body;
        logic       last;
        logic       short_str;
        logic [7:0] length;
        logic [7:0] country_first;
        logic [7:0] country_second;
        logic [6:0] prefix_rem;
        logic [6:0] prefix_pow;
    } entry_t;

    // Remainder mod 97 of a value below 2^14, by reciprocal multiplication.
    function automatic logic [6:0] mod97(input logic [13:0] x);
        logic [27:0] prod;
        logic [7:0]  quot;
        logic [14:0] diff;
        prod = 28'(x) * 28'(MOD_RECIP);
        quot = prod[RECIP_SHIFT +: 8];
        diff = 15'(x) - 15'(quot) * 15'(MODULUS);
        if (diff >= 15'(MODULUS)) begin
            diff = diff - 15'(MODULUS);
        end
        return diff[6:0];
    endfunction

    // Appends the decimal digits of one character value to a remainder.
    function automatic logic [6:0] fold(input logic [6:0] rem, input logic [5:0] value);
        logic [6:0] res;
        if (value <= LAST_DIGIT) begin
            res = mod97(14'(rem) * 14'd10 + 14'(value));
        end else if (value <= LAST_LETTER) begin
            res = mod97(14'(rem) * 14'd100 + 14'(value));
        end else begin
            res = rem;
        end
        return res;
    endfunction

    // Tracks 10^n mod 97 for the number of digits n that one value adds.
    function automatic logic [6:0] pow_step(input logic [6:0] pow, input logic [5:0] value);
        logic [6:0] res;
        if (value <= LAST_DIGIT) begin
            res = mod97(14'(pow) * 14'd10);
        end else if (value <= LAST_LETTER) begin
            res = mod97(14'(pow) * 14'd100);
        end else begin
            res = pow;
        end
        return res;
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] res;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            res = c - CASE_OFFSET;
        end else begin
            res = c;
        end
        return res;
    endfunction

    function automatic logic [5:0] char_value(input logic [7:0] c);
        logic [5:0] res;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            res = 6'(c - CHAR_ZERO);
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            res = 6'(c - LETTER_BIAS);
        end else begin
            res = SKIP_CODE;
        end
        return res;
    endfunction

endpackage

### rtl/core/iban_mod97_checker.sv
// ----------------------------------------------------------------------------
// IBAN mod-97 checker
// Streams IBAN text one byte per request and reports the mod 97-10 check.
//
//   Channel   Direction  Payload
//   s_        in         tdata[7:0] char_code, tlast last_char
//   m_        out        tdata[0] check_ok, [1] too_short, [9:2] text_length,
//                        [17:10] country_first, [25:18] country_second
//
// One character is taken every cycle while the queue is not full; each needs a single mod-97 fold.
// The queue is written at the edge that takes the last character, and the
// result then passes through the registered finish pipe: remainder fold,
// prefix multiply-add, final reduction.
// Reset is synchronous and clears all control state; no clearing pass runs.
// A stalled result output backs up through the finish pipe and the queue
// before s_tready falls.
// ----------------------------------------------------------------------------
module iban_mod97_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] check_ok, [1] too_short, [9:2] text_length,
                                   // [17:10] country_first, [25:18] country_second
);
    import imc_pkg::*;

    logic   q_push, q_full, q_pop, q_valid;
    entry_t q_in, q_out;

    imc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_entry  (q_in),
        .q_full   (q_full)
    );

    imc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .valid   (q_valid)
    );

    imc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/core/imc_front.sv
// ----------------------------------------------------------------------------
// IBAN checker front end
// Accepts characters, classifies them and folds the held-back prefix.
// ----------------------------------------------------------------------------
module imc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] char_code
    input  logic              s_tlast,
    output logic              q_push,
    output imc_pkg::entry_t   q_entry,
    input  logic              q_full
);
    import imc_pkg::*;

    logic [7:0] count_reg,  count_next;
    logic [7:0] first_reg,  first_next;
    logic [7:0] second_reg, second_next;
    logic [6:0] prem_reg,   prem_next;
    logic [6:0] pow_reg,    pow_next;
    logic       seen_reg,   seen_next;

    logic [7:0] upper;
    logic [5:0] value;
    logic       in_prefix;
    logic [7:0] count_inc;
    logic [7:0] first_upd, second_upd;
    logic [6:0] prem_upd, pow_upd;
    logic       seen_upd;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign upper     = fold_upper(s_tdata);
    assign value     = char_value(upper);
    assign in_prefix = count_reg < 8'(ROTATE_COUNT);

    always_comb begin
        count_inc  = (count_reg == MAX_COUNT) ? count_reg : count_reg + 8'd1;
        first_upd  = (count_reg == 8'd0) ? upper : first_reg;
        second_upd = (count_reg == 8'd1) ? upper : second_reg;
        prem_upd   = in_prefix ? fold(prem_reg, value) : prem_reg;
        pow_upd    = in_prefix ? pow_step(pow_reg, value) : pow_reg;
        seen_upd   = seen_reg || (value != SKIP_CODE);

        q_entry.value          = value;
        q_entry.body           = !in_prefix;
        q_entry.last           = s_tlast;
        q_entry.short_str      = (count_inc < 8'(ROTATE_COUNT)) || !seen_upd;
        q_entry.length         = count_inc;
        q_entry.country_first  = first_upd;
        q_entry.country_second = second_upd;
        q_entry.prefix_rem     = prem_upd;
        q_entry.prefix_pow     = pow_upd;

        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        prem_next   = prem_reg;
        pow_next    = pow_reg;
        seen_next   = seen_reg;
        if (q_push) begin
            if (s_tlast) begin
                // The string is complete; start the next one from scratch.
                count_next  = 8'd0;
                first_next  = 8'd0;
                second_next = 8'd0;
                prem_next   = 7'd0;
                pow_next    = 7'd1;
                seen_next   = 1'b0;
            end else begin
                count_next  = count_inc;
                first_next  = first_upd;
                second_next = second_upd;
                prem_next   = prem_upd;
                pow_next    = pow_upd;
                seen_next   = seen_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 8'd0;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
            prem_reg   <= 7'd0;
            pow_reg    <= 7'd1;
            seen_reg   <= 1'b0;
        end else begin
            count_reg  <= count_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            prem_reg   <= prem_next;
            pow_reg    <= pow_next;
            seen_reg   <= seen_next;
        end
    end

    // A power of ten is never a multiple of 97, so the tracked power stays nonzero.
    a_pow_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pow_reg != 7'd0) && (pow_reg < MODULUS) && (prem_reg < MODULUS))
        else $error("prefix power or remainder out of range");

endmodule

### rtl/core/imc_fifo.sv
// ----------------------------------------------------------------------------
// IBAN checker request queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module imc_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  imc_pkg::entry_t   din,
    output logic              full,
    input  logic              pop,
    output imc_pkg::entry_t   dout,
    output logic              valid
);
    import imc_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push, do_pop;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign dout    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_W'(QUEUE_DEPTH)) && !(pop && !valid))
        else $error("queue occupancy out of range or pop from empty queue");

endmodule

### rtl/core/imc_back.sv
// ----------------------------------------------------------------------------
// IBAN checker back end
// Folds body characters into the remainder and finishes each string.
// ----------------------------------------------------------------------------
module imc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  imc_pkg::entry_t   q_entry,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata    // [0] check_ok, [1] too_short, [9:2] text_length,
                                         // [17:10] country_first, [25:18] country_second
);
    import imc_pkg::*;

    typedef struct packed {
        logic       short_str;
        logic [7:0] length;
        logic [7:0] country_first;
        logic [7:0] country_second;
    } tail_t;

    logic [6:0]  rem_reg, rem_next;
    logic [6:0]  rem_after;

    logic        f1_valid_reg, f1_valid_next;
    logic [6:0]  f1_rem_reg, f1_pow_reg, f1_prem_reg;
    tail_t       f1_tail_reg;

    logic        f2_valid_reg, f2_valid_next;
    logic [13:0] f2_sum_reg;
    tail_t       f2_tail_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_ok_reg;
    tail_t       out_tail_reg;

    logic        o_free, f2_free, f1_free;
    logic [6:0]  final_rem;

    assign o_free  = !out_valid_reg || m_tready;
    assign f2_free = !f2_valid_reg || o_free;
    assign f1_free = !f1_valid_reg || f2_free;

    // Body characters never wait; a last character needs room in the finish pipe.
    assign q_pop     = q_valid && (!q_entry.last || f1_free);
    assign rem_after = q_entry.body ? fold(rem_reg, q_entry.value) : rem_reg;
    assign final_rem = mod97(f2_sum_reg);

    always_comb begin
        rem_next = rem_reg;
        if (q_pop) begin
            rem_next = q_entry.last ? 7'd0 : rem_after;
        end
        f1_valid_next  = f1_free ? (q_pop && q_entry.last) : f1_valid_reg;
        f2_valid_next  = f2_free ? f1_valid_reg : f2_valid_reg;
        out_valid_next = o_free ? f2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg       <= 7'd0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rem_reg       <= rem_next;
            f1_valid_reg  <= f1_valid_next;
            f2_valid_reg  <= f2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_free && q_pop && q_entry.last) begin
            f1_rem_reg                 <= rem_after;
            f1_pow_reg                 <= q_entry.prefix_pow;
            f1_prem_reg                <= q_entry.prefix_rem;
            f1_tail_reg.short_str      <= q_entry.short_str;
            f1_tail_reg.length         <= q_entry.length;
            f1_tail_reg.country_first  <= q_entry.country_first;
            f1_tail_reg.country_second <= q_entry.country_second;
        end
        if (f2_free && f1_valid_reg) begin
            // The held prefix goes after the body: body * 10^n + prefix.
            f2_sum_reg  <= 14'(f1_rem_reg) * 14'(f1_pow_reg) + 14'(f1_prem_reg);
            f2_tail_reg <= f1_tail_reg;
        end
        if (o_free && f2_valid_reg) begin
            out_ok_reg   <= !f2_tail_reg.short_str && (final_rem == 7'd1);
            out_tail_reg <= f2_tail_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_tail_reg.country_second, out_tail_reg.country_first,
                       out_tail_reg.length, out_tail_reg.short_str, out_ok_reg};

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < MODULUS)
        else $error("running remainder out of range");

    a_ok_not_short: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_ok_reg && out_tail_reg.short_str))
        else $error("check passed on a short string");

    a_rem_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.last) |=> (rem_reg == 7'd0))
        else $error("remainder not cleared after the last character");

endmodule
